/* rtl/aledser_pkg.sv */
package aledser_pkg;

  localparam int COLOR_BITS       = 24;
  localparam int PIXEL_INDEX_BITS = 7;
  localparam int POINTER_BITS     = 8;
  localparam int PULSE_BITS       = 16;
  localparam int INDEX_SPAN       = 1 << PIXEL_INDEX_BITS;

  // Item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LATCH = 2'd2;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] REG_ONE_PULSE   = 2'd1;
  localparam logic [1:0] REG_ZERO_PULSE  = 2'd2;
  localparam logic [1:0] REG_LATCH_SLOTS = 2'd3;

  localparam logic [POINTER_BITS-1:0] RST_PIXEL_COUNT = 8'd100;
  localparam logic [PULSE_BITS-1:0]   RST_ONE_PULSE   = 16'd300;
  localparam logic [PULSE_BITS-1:0]   RST_ZERO_PULSE  = 16'd20;
  localparam logic [POINTER_BITS-1:0] RST_LATCH_SLOTS = 8'd20;

  localparam logic [COLOR_BITS-1:0] TOP_BIT = {1'b1, {(COLOR_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                  func;
    logic                        draw_enable;
    logic [PIXEL_INDEX_BITS-1:0] pixel_index;
    logic [COLOR_BITS-1:0]       pixel_color;
  } in_item_t;

  typedef struct packed {
    logic                  compare_valid;
    logic [PULSE_BITS-1:0] compare_value;
    logic                  frame_done;
  } out_item_t;

  typedef struct packed {
    logic [POINTER_BITS-1:0] pixel_count;
    logic [PULSE_BITS-1:0]   one_pulse;
    logic [PULSE_BITS-1:0]   zero_pulse;
    logic [POINTER_BITS-1:0] latch_slots;
  } cfg_t;

  typedef struct packed {
    logic                        en;
    logic [PIXEL_INDEX_BITS-1:0] index;
    logic [COLOR_BITS-1:0]       color;
  } store_wr_t;

endpackage

/* rtl/addressable_led_bit_serializer_core.sv */
// Addressable LED bit serializer: turns stored 24-bit pixel colors into one
// PWM compare value per bit tick, MSB first, for a chain of serial LEDs.
// Input channel (in_valid/in_ready/in_data): one request per cycle unless stalled. A tick
// request with draw_enable set advances the serializer; a write request loads
// a pixel color; a latch request arms a run of zero-value reset slots.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// request, in order; compare_valid marks an emitted compare value, frame_done
// reports the frame-finished flag after the request.
// Path: an accepted request waits in the input register, and the result
// register loads from it when the request advances.
// Throughput: one request per cycle, limited only by output stalls; the
// serializer update is combinational and the one-read-port pixel memory is
// fetched ahead at the next pointer (with write forwarding).
// Stall: when out_ready is low with a result pending, the result register holds,
// the input register fills, and in_ready drops; nothing is lost or repeated.
// Reset (rst_n, synchronous): pointer, bit mask, latch/skip/done flags and
// registers return to defaults; pixel memory reads as zero through per-entry
// valid bits, so no clearing pass is needed.
// APB registers at 0x0 pixel_count, 0x4 one_pulse, 0x8 zero_pulse,
// 0xC latch_slots; write only while the block is idle.
module addressable_led_bit_serializer_core #(
  parameter int MAX_PIXELS = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aledser_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output aledser_pkg::out_item_t out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // pixel_index cannot address beyond INDEX_SPAN entries
  localparam int STORE_DEPTH = (MAX_PIXELS < aledser_pkg::INDEX_SPAN) ?
                               MAX_PIXELS : aledser_pkg::INDEX_SPAN;

  aledser_pkg::cfg_t                    cfg;
  aledser_pkg::store_wr_t               store_wr;
  logic [aledser_pkg::POINTER_BITS-1:0] rd_ptr;
  logic [aledser_pkg::COLOR_BITS-1:0]   rd_color;

  aledser_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pixel memory, read ahead through a registered port at the serializer's next pointer
  aledser_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (store_wr),
    .rd_ptr   (rd_ptr),
    .rd_color (rd_color)
  );

  aledser_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg),
    .rd_color  (rd_color),
    .rd_ptr    (rd_ptr),
    .store_wr  (store_wr)
  );

endmodule

/* rtl/aledser_regs.sv */
module aledser_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output aledser_pkg::cfg_t   cfg
);

  aledser_pkg::cfg_t cfg_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_count <= aledser_pkg::RST_PIXEL_COUNT;
      cfg_r.one_pulse   <= aledser_pkg::RST_ONE_PULSE;
      cfg_r.zero_pulse  <= aledser_pkg::RST_ZERO_PULSE;
      cfg_r.latch_slots <= aledser_pkg::RST_LATCH_SLOTS;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        aledser_pkg::REG_PIXEL_COUNT: cfg_r.pixel_count <= pwdata[7:0];
        aledser_pkg::REG_ONE_PULSE:   cfg_r.one_pulse   <= pwdata[15:0];
        aledser_pkg::REG_ZERO_PULSE:  cfg_r.zero_pulse  <= pwdata[15:0];
        aledser_pkg::REG_LATCH_SLOTS: cfg_r.latch_slots <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      aledser_pkg::REG_PIXEL_COUNT: prdata = {24'd0, cfg_r.pixel_count};
      aledser_pkg::REG_ONE_PULSE:   prdata = {16'd0, cfg_r.one_pulse};
      aledser_pkg::REG_ZERO_PULSE:  prdata = {16'd0, cfg_r.zero_pulse};
      aledser_pkg::REG_LATCH_SLOTS: prdata = {24'd0, cfg_r.latch_slots};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/aledser_store.sv */
module aledser_store #(
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  aledser_pkg::store_wr_t                  wr,
  input  logic [aledser_pkg::POINTER_BITS-1:0]    rd_ptr,
  output logic [aledser_pkg::COLOR_BITS-1:0]      rd_color
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [aledser_pkg::COLOR_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                   vld_r;
  logic [aledser_pkg::COLOR_BITS-1:0] rd_q_r;
  logic                               rd_vld_r;
  logic                               wr_ok;
  logic                               rd_ok;
  logic                               fwd;
  logic [AW-1:0]                      wr_addr;
  logic [AW-1:0]                      rd_addr;

  assign wr_ok   = wr.en && (32'(wr.index) < DEPTH);
  assign rd_ok   = 32'(rd_ptr) < DEPTH;
  assign wr_addr = AW'(wr.index);
  assign rd_addr = AW'(rd_ptr);
  // write-first: a write to the entry being fetched is forwarded
  assign fwd     = wr_ok && rd_ok && (32'(wr.index) == 32'(rd_ptr));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.color;
    end
    rd_q_r <= fwd ? wr.color : mem[rd_addr];
  end

  // valid bits stand in for the cleared-at-reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= fwd || (rd_ok && vld_r[rd_addr]);
    end
  end

  assign rd_color = rd_vld_r ? rd_q_r : '0;

endmodule

/* rtl/aledser_engine.sv */
module aledser_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  aledser_pkg::in_item_t                in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output aledser_pkg::out_item_t               out_data,
  input  aledser_pkg::cfg_t                    cfg,
  input  logic [aledser_pkg::COLOR_BITS-1:0]   rd_color,
  output logic [aledser_pkg::POINTER_BITS-1:0] rd_ptr,
  output aledser_pkg::store_wr_t               store_wr
);

  // input register
  logic                  s1_valid_r;
  aledser_pkg::in_item_t s1_data_r;
  // result register
  logic                   out_valid_r;
  aledser_pkg::out_item_t out_data_r;
  aledser_pkg::out_item_t res;

  logic [aledser_pkg::POINTER_BITS-1:0] ptr_r, ptr_nxt;
  logic [aledser_pkg::COLOR_BITS-1:0]   mask_r, mask_nxt, mask_shift;
  logic latch_r, latch_nxt;
  logic skip_r, skip_nxt;
  logic done_r, done_nxt;
  logic advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_ptr    = ptr_nxt;
  assign mask_shift = mask_r >> 1;

  assign store_wr.en    = advance && (s1_data_r.func == aledser_pkg::FUNC_WRITE);
  assign store_wr.index = s1_data_r.pixel_index;
  assign store_wr.color = s1_data_r.pixel_color;

  always_comb begin
    ptr_nxt   = ptr_r;
    mask_nxt  = mask_r;
    latch_nxt = latch_r;
    skip_nxt  = skip_r;
    done_nxt  = done_r;
    res.compare_valid = 1'b0;
    res.compare_value = '0;
    if (advance) begin
      case (s1_data_r.func)
        aledser_pkg::FUNC_TICK: begin
          if (s1_data_r.draw_enable) begin
            done_nxt = 1'b0;
            if (latch_r) begin
              if (ptr_r < cfg.latch_slots) begin
                res.compare_valid = 1'b1;
                ptr_nxt = ptr_r + 1'b1;
              end else begin
                ptr_nxt   = '0;
                latch_nxt = 1'b0;
              end
            end else if (skip_r) begin
              skip_nxt = 1'b0;
            end else if (ptr_r < cfg.pixel_count) begin
              res.compare_valid = 1'b1;
              res.compare_value = |(rd_color & mask_r) ? cfg.one_pulse : cfg.zero_pulse;
              if (mask_shift == '0) begin
                ptr_nxt  = ptr_r + 1'b1;
                mask_nxt = aledser_pkg::TOP_BIT;
              end else begin
                mask_nxt = mask_shift;
              end
            end else begin
              // frame end: zero slot, rewind, hold off the next tick
              res.compare_valid = 1'b1;
              ptr_nxt  = '0;
              mask_nxt = aledser_pkg::TOP_BIT;
              skip_nxt = 1'b1;
              done_nxt = 1'b1;
            end
          end
        end
        aledser_pkg::FUNC_LATCH: latch_nxt = 1'b1;
        default: ;
      endcase
    end
    res.frame_done = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      mask_r      <= aledser_pkg::TOP_BIT;
      latch_r     <= 1'b0;
      skip_r      <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      ptr_r   <= ptr_nxt;
      mask_r  <= mask_nxt;
      latch_r <= latch_nxt;
      skip_r  <= skip_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mask_r))
    else $error("bit mask lost its single set bit");

  a_idle_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.compare_valid |-> out_data_r.compare_value == '0)
    else $error("compare value nonzero without compare_valid");

  a_done_implies_skip: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> skip_r)
    else $error("frame done without pending skip");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_data_r.frame_done == done_r)
    else $error("processed request did not reach the result register");
`endif

endmodule
